// ===== sv/lsot_pkg.sv =====
`default_nettype none
package lsot_pkg;

    localparam int MAX_LAYERS_DEF = 16;

    typedef enum logic [2:0] {
        CMD_UPSERT    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_ABOVE     = 3'd2,
        CMD_BELOW     = 3'd3,
        CMD_SET_LOCAL = 3'd4,
        CMD_READ      = 3'd5
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NO_CHANGE = 3'd3,
        ST_FULL      = 3'd4
    } status_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic [31:0]        id;
        logic [31:0]        parent;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic [13:0]        w;
        logic [13:0]        h;
        logic               ext;
    } layer_rec_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        surface_id;
        logic [31:0]        sibling_id;
        logic [31:0]        parent_window;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] local_x;
        logic signed [15:0] local_y;
        logic [13:0]        width;
        logic [13:0]        height;
        logic               is_external;
        logic [3:0]         slot_index;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               slot_valid;
        logic [31:0]        slot_surface;
        logic [31:0]        slot_parent;
        logic signed [15:0] slot_x;
        logic signed [15:0] slot_y;
        logic signed [15:0] slot_local_x;
        logic signed [15:0] slot_local_y;
        logic [13:0]        slot_width;
        logic [13:0]        slot_height;
        logic               slot_external;
        logic [4:0]         layer_count;
    } rsp_beat_t;

endpackage
`default_nettype wire

// ===== sv/lsot_store.sv =====
`default_nettype none
module lsot_store
    import lsot_pkg::*;
#(
    parameter int MAX_LAYERS = MAX_LAYERS_DEF,
    localparam int IW = $clog2(MAX_LAYERS)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [IW-1:0] waddr,
    input  wire layer_rec_t    wdata,
    input  wire logic [IW-1:0] raddr,
    output layer_rec_t         rdata
);

    layer_rec_t mem [MAX_LAYERS];
    layer_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/layer_stack_order_table.sv =====
// A command beat is scanned against the stored entries, N the entry count
// (one slot compared per cycle); remove and place then shift up to N slots in S_MOVE.
// Throughput: one command at a time; the next beat is taken the cycle after
// the result beat is accepted.
// The key compare and the slot shift share the table's single read port.
// Reset: asynchronous, active low; clears the entry count and the sequencer, not the table.
`default_nettype none
module layer_stack_order_table
    import lsot_pkg::*;
#(
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_beat_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_beat_t rsp
);

    localparam int IW = $clog2(MAX_LAYERS);
    localparam int CW = $clog2(MAX_LAYERS + 1);
    localparam int XW = (CW > 4) ? CW : 4;

    seq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic          m_found_reg, m_found_next, s_found_reg, s_found_next;
    logic [IW-1:0] m_reg, m_next, s_reg, s_next;
    logic [IW-1:0] cur_reg, cur_next, to_reg, to_next;
    layer_rec_t    held_reg, held_next;
    cmd_beat_t     cmd_reg, cmd_next;
    rsp_beat_t     rsp_reg, rsp_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    layer_rec_t    wdata, rdata, new_rec;
    logic          hit_m, hit_s, scan_last;
    logic [IW:0]   m_w, s_w, k_w;
    logic          is_place;

    lsot_store #(.MAX_LAYERS(MAX_LAYERS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_found_reg <= 1'b0;
            s_found_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_found_reg <= m_found_next;
            s_found_reg <= s_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        m_reg    <= m_next;
        s_reg    <= s_next;
        cur_reg  <= cur_next;
        to_reg   <= to_next;
        held_reg <= held_next;
        cmd_reg  <= cmd_next;
        rsp_reg  <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp       = rsp_reg;

    assign hit_m     = (rdata.id == cmd_reg.surface_id);
    assign hit_s     = (rdata.id == cmd_reg.sibling_id);
    assign scan_last = ((CW'(scan_reg) + CW'(1)) == count_reg);
    assign m_w       = {1'b0, m_reg};
    assign s_w       = {1'b0, s_reg};
    assign is_place  = (cmd_reg.command == CMD_ABOVE) || (cmd_reg.command == CMD_BELOW);

    always_comb
    begin
        new_rec.id     = cmd_reg.surface_id;
        new_rec.parent = cmd_reg.parent_window;
        new_rec.ax     = cmd_reg.pos_x;
        new_rec.ay     = cmd_reg.pos_y;
        new_rec.lx     = cmd_reg.local_x;
        new_rec.ly     = cmd_reg.local_y;
        new_rec.w      = cmd_reg.width;
        new_rec.h      = cmd_reg.height;
        new_rec.ext    = cmd_reg.is_external;
        if (cmd_reg.command == CMD_ABOVE)
        begin
            k_w = (m_w < s_w) ? s_w : s_w + 1'b1;
        end
        else
        begin
            k_w = (m_w < s_w) ? s_w - 1'b1 : s_w;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        m_found_next = m_found_reg;
        s_found_next = s_found_reg;
        m_next       = m_reg;
        s_next       = s_reg;
        cur_next     = cur_reg;
        to_next      = to_reg;
        held_next    = held_reg;
        cmd_next     = cmd_reg;
        rsp_next     = rsp_reg;
        we           = 1'b0;
        waddr        = cur_reg;
        wdata        = rdata;
        raddr        = scan_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                raddr = '0;
                if (cmd_valid)
                begin
                    cmd_next     = cmd;
                    scan_next    = '0;
                    m_found_next = 1'b0;
                    s_found_next = 1'b0;
                    state_next   = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit_m && !m_found_reg)
                begin
                    m_found_next = 1'b1;
                    m_next       = scan_reg;
                end
                if (hit_s && !s_found_reg)
                begin
                    s_found_next = 1'b1;
                    s_next       = scan_reg;
                end
                scan_next = scan_reg + 1'b1;
                raddr     = scan_reg + 1'b1;
                if (scan_last)
                begin
                    state_next = S_DECIDE;
                    if (cmd_reg.command == CMD_READ)
                    begin
                        raddr = IW'(cmd_reg.slot_index);
                    end
                    else
                    begin
                        raddr = m_next;
                    end
                end
            end
            S_DECIDE:
            begin
                rsp_next        = '0;
                rsp_next.status = ST_NO_CHANGE;
                held_next       = rdata;
                cur_next        = m_reg;
                state_next      = S_RESP;
                case (cmd_reg.command)
                    CMD_UPSERT:
                    begin
                        if (m_found_reg)
                        begin
                            we              = 1'b1;
                            waddr           = m_reg;
                            wdata           = new_rec;
                            rsp_next.status = ST_REPLACED;
                        end
                        else if (count_reg < CW'(MAX_LAYERS))
                        begin
                            we              = 1'b1;
                            waddr           = IW'(count_reg);
                            wdata           = new_rec;
                            count_next      = count_reg + 1'b1;
                            rsp_next.status = ST_DONE;
                        end
                        else
                        begin
                            rsp_next.status = ST_FULL;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (m_found_reg)
                        begin
                            to_next         = IW'(count_reg - 1'b1);
                            count_next      = count_reg - 1'b1;
                            rsp_next.status = ST_DONE;
                            state_next      = S_MOVE;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_ABOVE, CMD_BELOW:
                    begin
                        if (!m_found_reg || !s_found_reg)
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                        else if ((m_w == s_w)
                                 || (cmd_reg.command == CMD_ABOVE && m_w == s_w + 1'b1)
                                 || (cmd_reg.command == CMD_BELOW && m_w + 1'b1 == s_w))
                        begin
                            rsp_next.status = ST_NO_CHANGE;
                        end
                        else
                        begin
                            to_next         = k_w[IW-1:0];
                            rsp_next.status = ST_DONE;
                            state_next      = S_MOVE;
                        end
                    end
                    CMD_SET_LOCAL:
                    begin
                        if (m_found_reg)
                        begin
                            we              = 1'b1;
                            waddr           = m_reg;
                            wdata           = rdata;
                            wdata.lx        = cmd_reg.local_x;
                            wdata.ly        = cmd_reg.local_y;
                            rsp_next.status = ST_DONE;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_READ:
                    begin
                        if (XW'(cmd_reg.slot_index) < XW'(count_reg))
                        begin
                            rsp_next.status        = ST_DONE;
                            rsp_next.slot_valid    = 1'b1;
                            rsp_next.slot_surface  = rdata.id;
                            rsp_next.slot_parent   = rdata.parent;
                            rsp_next.slot_x        = rdata.ax;
                            rsp_next.slot_y        = rdata.ay;
                            rsp_next.slot_local_x  = rdata.lx;
                            rsp_next.slot_local_y  = rdata.ly;
                            rsp_next.slot_width    = rdata.w;
                            rsp_next.slot_height   = rdata.h;
                            rsp_next.slot_external = rdata.ext;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_NO_CHANGE;
                    end
                endcase
                if (to_next > m_reg)
                begin
                    raddr = m_reg + 1'b1;
                end
                else
                begin
                    raddr = m_reg - 1'b1;
                end
                rsp_next.layer_count = 5'(count_next);
            end
            S_MOVE:
            begin
                we    = 1'b1;
                waddr = cur_reg;
                if (cur_reg == to_reg)
                begin
                    wdata      = held_reg;
                    state_next = S_RESP;
                end
                else if (cur_reg < to_reg)
                begin
                    wdata    = rdata;
                    cur_next = cur_reg + 1'b1;
                    raddr    = cur_next + 1'b1;
                end
                else
                begin
                    wdata    = rdata;
                    cur_next = cur_reg - 1'b1;
                    raddr    = cur_next - 1'b1;
                end
            end
            S_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LAYERS))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1)
        || (count_reg + 1'b1 == $past(count_reg)))
        else $error("entry count jumped");

    a_count_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DECIDE) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside decide");

    a_move_place: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> (is_place || cmd_reg.command == CMD_REMOVE))
        else $error("slot shift on a command that moves nothing");

endmodule
`default_nettype wire

// ===== tb/layer_stack_order_table_tb.sv =====
`timescale 1ns / 1ps
module layer_stack_order_table_tb;
    import lsot_pkg::*;

    localparam int DEPTH = MAX_LAYERS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_beat_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_beat_t rsp;

    layer_rec_t stack_model[DEPTH];
    int unsigned stack_depth;
    rsp_beat_t pending_rsp[$];
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    bit busy_idle;
    int unsigned id_pool[8];

    layer_stack_order_table DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    function automatic int find_layer(logic [31:0] key);
        for (int i = 0; i < stack_depth; i++)
        begin
            if (stack_model[i].id == key)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void shift_layer(int from, int to);
        layer_rec_t held;
        held = stack_model[from];
        if (from < to)
        begin
            for (int i = from; i < to; i++)
            begin
                stack_model[i] = stack_model[i + 1];
            end
        end
        else
        begin
            for (int i = from; i > to; i--)
            begin
                stack_model[i] = stack_model[i - 1];
            end
        end
        stack_model[to] = held;
    endfunction

    function automatic rsp_beat_t apply_stack_cmd(cmd_beat_t c);
        rsp_beat_t r;
        layer_rec_t e;
        int m;
        int s;
        int k;
        r = '0;
        r.status = ST_NO_CHANGE;
        case (c.command)
            CMD_UPSERT:
            begin
                e.id = c.surface_id;
                e.parent = c.parent_window;
                e.ax = c.pos_x;
                e.ay = c.pos_y;
                e.lx = c.local_x;
                e.ly = c.local_y;
                e.w = c.width;
                e.h = c.height;
                e.ext = c.is_external;
                m = find_layer(c.surface_id);
                if (m >= 0)
                begin
                    stack_model[m] = e;
                    r.status = ST_REPLACED;
                end
                else if (stack_depth < DEPTH)
                begin
                    stack_model[stack_depth] = e;
                    stack_depth++;
                    r.status = ST_DONE;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            CMD_REMOVE:
            begin
                m = find_layer(c.surface_id);
                if (m < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    shift_layer(m, stack_depth - 1);
                    stack_depth--;
                    r.status = ST_DONE;
                end
            end
            CMD_ABOVE, CMD_BELOW:
            begin
                m = find_layer(c.surface_id);
                s = find_layer(c.sibling_id);
                if (m < 0 || s < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else if (m == s || (c.command == CMD_ABOVE && m == s + 1)
                         || (c.command == CMD_BELOW && m == s - 1))
                begin
                    r.status = ST_NO_CHANGE;
                end
                else
                begin
                    if (c.command == CMD_ABOVE)
                    begin
                        k = (m < s) ? s : s + 1;
                    end
                    else
                    begin
                        k = (m < s) ? s - 1 : s;
                    end
                    shift_layer(m, k);
                    r.status = ST_DONE;
                end
            end
            CMD_SET_LOCAL:
            begin
                m = find_layer(c.surface_id);
                if (m < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    stack_model[m].lx = c.local_x;
                    stack_model[m].ly = c.local_y;
                    r.status = ST_DONE;
                end
            end
            CMD_READ:
            begin
                if (c.slot_index < stack_depth)
                begin
                    e = stack_model[c.slot_index];
                    r.slot_valid = 1'b1;
                    r.slot_surface = e.id;
                    r.slot_parent = e.parent;
                    r.slot_x = e.ax;
                    r.slot_y = e.ay;
                    r.slot_local_x = e.lx;
                    r.slot_local_y = e.ly;
                    r.slot_width = e.w;
                    r.slot_height = e.h;
                    r.slot_external = e.ext;
                    r.status = ST_DONE;
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                r.status = ST_NO_CHANGE;
            end
        endcase
        r.layer_count = stack_depth[4:0];
        return r;
    endfunction

    task automatic send_beat(cmd_beat_t c);
        while (!busy_idle && $urandom_range(99) < 7)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        pending_rsp = {pending_rsp, apply_stack_cmd(c)};
    endtask

    function automatic cmd_beat_t random_fields();
        cmd_beat_t c;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(cmd_beat_t)-1:0];
        return c;
    endfunction

    function automatic cmd_beat_t make_cmd(logic [2:0] op, logic [31:0] sid,
                                           logic [31:0] sib);
        cmd_beat_t c;
        c = random_fields();
        c.command = op;
        c.surface_id = sid;
        c.sibling_id = sib;
        return c;
    endfunction

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_extremes();
        cmd_beat_t c;
        send_beat(make_cmd(CMD_READ, 0, 0));
        send_beat(make_cmd(CMD_REMOVE, 5, 0));
        c = make_cmd(CMD_UPSERT, 32'hFFFF_FFFF, 0);
        c.parent_window = '1;
        c.pos_x = 16'sh7FFF;
        c.pos_y = 16'sh8000;
        c.local_x = 16'sh8000;
        c.local_y = 16'sh7FFF;
        c.width = '1;
        c.height = '1;
        c.is_external = 1'b1;
        send_beat(c);
        c = '0;
        c.command = CMD_UPSERT;
        send_beat(c);
        c.slot_index = 4'd0;
        c.command = CMD_READ;
        send_beat(c);
        c.slot_index = 4'd1;
        send_beat(c);
        c.slot_index = 4'hF;
        send_beat(c);
        send_beat(make_cmd(CMD_UPSERT, 0, 0));
        send_beat(make_cmd(CMD_SET_LOCAL, 0, 0));
        send_beat(make_cmd(CMD_SET_LOCAL, 77, 0));
        send_beat(make_cmd(CMD_SPARE_LO, 0, 0));
        send_beat(make_cmd(CMD_SPARE_HI, 0, 0));
    endtask

    task automatic test_placement();
        send_beat(make_cmd(CMD_UPSERT, 1, 0));
        send_beat(make_cmd(CMD_ABOVE, 0, 0));
        send_beat(make_cmd(CMD_ABOVE, 0, 99));
        send_beat(make_cmd(CMD_BELOW, 99, 0));
        send_beat(make_cmd(CMD_ABOVE, 1, 0));
        send_beat(make_cmd(CMD_ABOVE, 0, 1));
        send_beat(make_cmd(CMD_BELOW, 32'hFFFF_FFFF, 0));
        send_beat(make_cmd(CMD_BELOW, 1, 32'hFFFF_FFFF));
        send_beat(make_cmd(CMD_REMOVE, 0, 0));
        send_beat(make_cmd(CMD_READ, 0, 0));
    endtask

    task automatic test_full_stack();
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            send_beat(make_cmd(CMD_UPSERT, 32'h100 + i, 0));
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            cmd_beat_t c;
            c = make_cmd(CMD_READ, 0, 0);
            c.slot_index = 4'(i);
            send_beat(c);
        end
        send_beat(make_cmd(CMD_ABOVE, 32'h100, 32'h10F));
        send_beat(make_cmd(CMD_BELOW, 32'h10F, 32'h100));
        for (int i = 0; i < DEPTH + 3; i++)
        begin
            send_beat(make_cmd(CMD_REMOVE, 32'h100 + i, 0));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(int unsigned count);
        cmd_beat_t c;
        int unsigned pick;
        for (int i = 0; i < 8; i++)
        begin
            id_pool[i] = $urandom;
        end
        for (int unsigned n = 0; n < count; n++)
        begin
            busy_idle = (n >= count / 3 && n < count / 2);
            c = random_fields();
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                c.command = CMD_UPSERT;
            end
            else if (pick < 40)
            begin
                c.command = CMD_REMOVE;
            end
            else if (pick < 65)
            begin
                c.command = ($urandom_range(1)) ? CMD_ABOVE : CMD_BELOW;
            end
            else if (pick < 75)
            begin
                c.command = CMD_SET_LOCAL;
            end
            else if (pick < 97)
            begin
                c.command = CMD_READ;
            end
            if ($urandom_range(9) != 0)
            begin
                c.surface_id = id_pool[$urandom_range(7)];
            end
            if ($urandom_range(9) != 0)
            begin
                c.sibling_id = id_pool[$urandom_range(7)];
            end
            if ($urandom_range(49) == 0)
            begin
                id_pool[$urandom_range(7)] = $urandom;
            end
            if (n == count / 4)
            begin
                wait_drained();
            end
            send_beat(c);
        end
        busy_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rsp_stall <= (!busy_idle && $urandom_range(99) < 7);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result with nothing expected: %h", rsp);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.slot_valid !== want.slot_valid)
                begin
                    $error("slot_valid expected %0d got %0d", want.slot_valid, rsp.slot_valid);
                    error_count++;
                end
                if (rsp.slot_surface !== want.slot_surface)
                begin
                    $error("slot_surface expected %h got %h", want.slot_surface,
                           rsp.slot_surface);
                    error_count++;
                end
                if (rsp.slot_parent !== want.slot_parent)
                begin
                    $error("slot_parent expected %h got %h", want.slot_parent, rsp.slot_parent);
                    error_count++;
                end
                if (rsp.slot_x !== want.slot_x)
                begin
                    $error("slot_x expected %0d got %0d", want.slot_x, rsp.slot_x);
                    error_count++;
                end
                if (rsp.slot_y !== want.slot_y)
                begin
                    $error("slot_y expected %0d got %0d", want.slot_y, rsp.slot_y);
                    error_count++;
                end
                if (rsp.slot_local_x !== want.slot_local_x)
                begin
                    $error("slot_local_x expected %0d got %0d", want.slot_local_x,
                           rsp.slot_local_x);
                    error_count++;
                end
                if (rsp.slot_local_y !== want.slot_local_y)
                begin
                    $error("slot_local_y expected %0d got %0d", want.slot_local_y,
                           rsp.slot_local_y);
                    error_count++;
                end
                if (rsp.slot_width !== want.slot_width)
                begin
                    $error("slot_width expected %0d got %0d", want.slot_width, rsp.slot_width);
                    error_count++;
                end
                if (rsp.slot_height !== want.slot_height)
                begin
                    $error("slot_height expected %0d got %0d", want.slot_height,
                           rsp.slot_height);
                    error_count++;
                end
                if (rsp.slot_external !== want.slot_external)
                begin
                    $error("slot_external expected %0d got %0d", want.slot_external,
                           rsp.slot_external);
                    error_count++;
                end
                if (rsp.layer_count !== want.layer_count)
                begin
                    $error("layer_count expected %0d got %0d", want.layer_count,
                           rsp.layer_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("layer_stack_order_table_tb failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        stack_depth = 0;
        busy_idle = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_placement();
        test_full_stack();
        test_random_traffic(520);
        wait_drained();
        repeat (100) @(posedge clk);
        if (error_count == 0)
        begin
            $display("layer_stack_order_table_tb passed");
        end
        else
        begin
            $display("layer_stack_order_table_tb failed");
        end
        $finish;
    end

endmodule
